// ===== rtl/srsbc_pkg.sv =====
// Shared types and constants of the serial receive silo.
package srsbc_pkg;

  // Configuration data width and register indexes
  localparam int unsigned CFG_DW = 8;

  typedef enum logic [1:0] {
    CFG_LINE_OPEN      = 2'd0,
    CFG_DIALOUT_MODE   = 2'd1,
    CFG_SOFT_THRESHOLD = 2'd2,
    CFG_BATCH_LIMIT    = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] SOFT_THRESHOLD_RST = 8'd20;
  localparam logic [5:0] BATCH_LIMIT_RST    = 6'd20;
  localparam logic [5:0] BATCH_MAX          = 6'd60;

  // Item actions
  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_STATUS = 2'd1,
    ACT_ERROR  = 2'd2,
    ACT_PASS   = 2'd3
  } action_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_BREAK    = 3'd1,
    KIND_UP       = 3'd2,
    KIND_LOST     = 3'd3,
    KIND_OVERFLOW = 3'd4,
    KIND_DONE     = 3'd5
  } kind_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] rx_byte;
    logic       break_now;
    logic       carrier_now;
    logic       data_overrun;
    logic       downstream_full;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       more_pending;
    logic       soft_request;
    logic       last;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CARRIER,
    ST_OVERRUN,
    ST_BREAK,
    ST_DRAIN,
    ST_DELIVER,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/srsbc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface srsbc_in_if;
  import srsbc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface srsbc_out_if;
  import srsbc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/srsbc_ring.sv =====
// Byte store of the receive silo: one write port, one registered read port.
module srsbc_ring #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Store received byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data; hold it between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/serial_rx_silo_break_carrier.sv =====
// Serial receive silo: byte store, break and carrier events, process passes.
// Byte, status and error items are accepted in idle; the done state then registers the done result.
// A pass steps through carrier, overrun, break, then drain and deliver per byte, then done.
// Each byte costs one read of the store's single read port and one pass through the deliver state.
// A result waits in one output register; the sequencer stalls only while it is full.
// rst_n (synchronous) clears indexes, flags and configuration; store contents are not cleared.
module serial_rx_silo_break_carrier #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  srsbc_in_if.sink                      in_ch,
  srsbc_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [srsbc_pkg::CFG_DW-1:0]  cfg_wdata
);
  import srsbc_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  // Configuration registers
  logic       line_open_r;
  logic       dialout_r;
  logic [7:0] soft_thr_r;
  logic [5:0] batch_r;

  // Silo state
  state_t        state_r, state_nxt;
  in_item_t      item_r;
  logic [AW-1:0] wr_idx_r, rd_idx_r;
  logic          ovr_r, brk_pend_r, cev_r, last_brk_r, carrier_on_r;
  logic [7:0]    soft_cnt_r;
  logic [5:0]    cnt_r;
  logic          more_r, soft_r;

  // Output register
  logic      out_vld_r;
  out_item_t out_pl_r;

  // Sequencer controls
  logic      out_free, accept, emit, adv, deliver, drain_go, avail, keep;
  logic      mem_we, mem_re;
  out_item_t emit_pl;
  logic [7:0] rdata;
  logic [5:0] limit;
  logic [AW-1:0] wr_next, rd_next;
  logic [8:0] soft_sum;

  assign out_free = !out_vld_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;
  assign deliver  = line_open_r && !item_r.downstream_full;
  assign avail    = (rd_idx_r != wr_idx_r);
  assign keep     = !((in_ch.payload.rx_byte == 8'd0) && last_brk_r);
  assign wr_next  = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign rd_next  = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
  assign soft_sum = {1'b0, soft_cnt_r} + 9'd1;

  // Clamp batch limit to 1..60
  always_comb begin
    if (batch_r == 6'd0) begin
      limit = 6'd1;
    end else if (batch_r > BATCH_MAX) begin
      limit = BATCH_MAX;
    end else begin
      limit = batch_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_open_r <= 1'b0;
      dialout_r   <= 1'b0;
      soft_thr_r  <= SOFT_THRESHOLD_RST;
      batch_r     <= BATCH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINE_OPEN:      line_open_r <= cfg_wdata[0];
        CFG_DIALOUT_MODE:   dialout_r   <= cfg_wdata[0];
        CFG_SOFT_THRESHOLD: soft_thr_r  <= cfg_wdata[7:0];
        CFG_BATCH_LIMIT:    batch_r     <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer outputs: result push, advance, memory access
  always_comb begin
    in_ch.ready = 1'b0;
    emit        = 1'b0;
    adv         = 1'b0;
    drain_go    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    emit_pl     = '{kind: KIND_DONE, out_byte: 8'd0, more_pending: 1'b0,
                    soft_request: 1'b0, last: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_we      = accept && (in_ch.payload.action == ACT_BYTE) && keep;
      end
      ST_CARRIER: begin
        if (cev_r && item_r.carrier_now && !carrier_on_r) begin
          emit_pl.kind = KIND_UP;
          emit         = out_free;
          adv          = out_free;
        end else if (cev_r && !item_r.carrier_now && carrier_on_r && !dialout_r
                     && line_open_r) begin
          emit_pl.kind = KIND_LOST;
          emit         = out_free;
          adv          = out_free;
        end else begin
          adv = 1'b1;
        end
      end
      ST_OVERRUN: begin
        if (ovr_r && line_open_r) begin
          emit_pl.kind = KIND_OVERFLOW;
          emit         = out_free;
          adv          = out_free;
        end else begin
          adv = 1'b1;
        end
      end
      ST_BREAK: begin
        if (brk_pend_r && !item_r.break_now && deliver) begin
          emit_pl.kind = KIND_BREAK;
          emit         = out_free;
          adv          = out_free;
        end else begin
          adv = 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_go = avail && (cnt_r < limit);
        mem_re   = drain_go;
        adv      = 1'b1;
      end
      ST_DELIVER: begin
        if (deliver) begin
          emit_pl.kind     = KIND_BYTE;
          emit_pl.out_byte = rdata;
          emit             = out_free;
          adv              = out_free;
        end else begin
          adv = 1'b1;
        end
      end
      ST_DONE: begin
        emit_pl.kind         = KIND_DONE;
        emit_pl.more_pending = more_r;
        emit_pl.soft_request = soft_r;
        emit_pl.last         = 1'b1;
        emit                 = out_free;
        adv                  = out_free;
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.payload.action == ACT_PASS) ? ST_CARRIER : ST_DONE;
        end
      end
      ST_CARRIER: if (adv) state_nxt = ST_OVERRUN;
      ST_OVERRUN: if (adv) state_nxt = ST_BREAK;
      ST_BREAK:   if (adv) state_nxt = ST_DRAIN;
      ST_DRAIN:   state_nxt = drain_go ? ST_DELIVER : ST_DONE;
      ST_DELIVER: if (adv) state_nxt = ST_DRAIN;
      ST_DONE:    if (adv) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_ch.payload;
    end
  end

  // Silo state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r     <= '0;
      rd_idx_r     <= '0;
      ovr_r        <= 1'b0;
      brk_pend_r   <= 1'b0;
      cev_r        <= 1'b0;
      last_brk_r   <= 1'b0;
      carrier_on_r <= 1'b0;
      soft_cnt_r   <= 8'd0;
      cnt_r        <= 6'd0;
      more_r       <= 1'b0;
      soft_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            more_r <= 1'b0;
            soft_r <= 1'b0;
            cnt_r  <= 6'd0;
            case (in_ch.payload.action)
              ACT_BYTE: begin
                if (keep) begin
                  wr_idx_r <= wr_next;
                  if (wr_next == rd_idx_r) ovr_r <= 1'b1;
                  if (soft_sum > {1'b0, soft_thr_r}) begin
                    soft_cnt_r <= 8'd0;
                    soft_r     <= 1'b1;
                  end else begin
                    soft_cnt_r <= soft_sum[7:0];
                  end
                end
              end
              ACT_STATUS: begin
                if (last_brk_r && !in_ch.payload.break_now) brk_pend_r <= 1'b1;
                last_brk_r <= in_ch.payload.break_now;
                cev_r      <= 1'b1;
                soft_r     <= 1'b1;
              end
              ACT_ERROR: begin
                if (in_ch.payload.data_overrun) begin
                  ovr_r  <= 1'b1;
                  soft_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CARRIER: begin
          if (adv && cev_r) begin
            cev_r <= 1'b0;
            if (item_r.carrier_now) begin
              carrier_on_r <= 1'b1;
            end else if (carrier_on_r && !dialout_r) begin
              carrier_on_r <= 1'b0;
            end
          end
        end
        ST_OVERRUN: begin
          if (adv && ovr_r) begin
            ovr_r    <= 1'b0;
            wr_idx_r <= '0;
            rd_idx_r <= '0;
          end
        end
        ST_BREAK: begin
          if (adv && brk_pend_r && !item_r.break_now) brk_pend_r <= 1'b0;
        end
        ST_DRAIN: begin
          if (drain_go) begin
            rd_idx_r <= rd_next;
            cnt_r    <= cnt_r + 6'd1;
          end else begin
            more_r <= (cnt_r >= limit) && avail;
            soft_r <= (cnt_r >= limit) && avail;
          end
        end
        default: ;
      endcase
    end
  end

  // Byte store; writes happen only in idle and reads only while draining
  srsbc_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx_r),
    .wdata (in_ch.payload.rx_byte),
    .re    (mem_re),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pl_r <= emit_pl;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_pl_r;

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after accepting an item");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r <= limit))
    else $error("drain count exceeded batch limit");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_idx_r <= LAST_IDX) && (wr_idx_r <= LAST_IDX))
    else $error("silo index out of range");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (rd_idx_r != wr_idx_r) && !mem_we)
    else $error("store read while empty or during a write");

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_pl_r.last == (out_pl_r.kind == KIND_DONE)))
    else $error("last flag does not match done result");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the serial receive silo: driver, monitor and predictor.
`timescale 1ns / 100ps

module testbench;
  import srsbc_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  srsbc_in_if  in_ch ();
  srsbc_out_if out_ch ();

  serial_rx_silo_break_carrier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock: 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Items waiting to be offered, results still owed by the block
  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        queued_total = 0;
  int        error_count = 0;

  // Idle rates of both sides and the long receiver hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stall_seen = 0;
  int stall_left = 0;

  // Predicted silo state and shadow of the configuration registers
  logic [7:0] silo_mem [256];
  logic [7:0] silo_wr;
  logic [7:0] silo_rd;
  bit         overrun_seen;
  bit         break_due;
  bit         carrier_evt;
  int         soft_count;
  bit         line_in_break;
  bit         carrier_up;
  bit         open_q;
  bit         dialout_q;
  logic [7:0] soft_limit;
  logic [5:0] batch_reg;

  // Line state that the stimulus keeps consistent across a sequence
  bit gen_brk;
  bit gen_car;

  task automatic report_mismatch(string msg);
    if (error_count < 50) $display("%0t ns: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void push_result(kind_t k, logic [7:0] b, logic more, logic soft_req,
                                      logic fin);
    out_item_t r;
    r.kind = k;
    r.out_byte = b;
    r.more_pending = more;
    r.soft_request = soft_req;
    r.last = fin;
    expected_results.push_back(r);
  endfunction

  // Work out the results of one accepted item and advance the silo state
  function automatic void predict_results(in_item_t it);
    int   cap;
    int   drained;
    bit   deliver;
    logic soft_req;
    logic more;
    soft_req = 1'b0;
    more = 1'b0;
    drained = 0;
    case (it.action)
      ACT_BYTE: begin
        // a null byte during break is dropped and not counted
        if (!(it.rx_byte == 8'h00 && line_in_break)) begin
          silo_mem[silo_wr] = it.rx_byte;
          silo_wr++;
          if (silo_wr == silo_rd) overrun_seen = 1'b1;
          if (soft_count + 1 > int'(soft_limit)) begin
            soft_count = 0;
            soft_req = 1'b1;
          end else begin
            soft_count++;
          end
        end
      end
      ACT_STATUS: begin
        if (line_in_break && !it.break_now) break_due = 1'b1;
        line_in_break = it.break_now;
        carrier_evt = 1'b1;
        soft_req = 1'b1;
      end
      ACT_ERROR: begin
        if (it.data_overrun) begin
          overrun_seen = 1'b1;
          soft_req = 1'b1;
        end
      end
      ACT_PASS: begin
        cap = (batch_reg == 6'd0) ? 1 : (batch_reg > BATCH_MAX) ? int'(BATCH_MAX)
                                                                : int'(batch_reg);
        deliver = open_q && !it.downstream_full;
        // carrier event first
        if (carrier_evt) begin
          carrier_evt = 1'b0;
          if (it.carrier_now) begin
            if (!carrier_up) push_result(KIND_UP, 8'h00, 1'b0, 1'b0, 1'b0);
            carrier_up = 1'b1;
          end else if (carrier_up && !dialout_q) begin
            if (open_q) push_result(KIND_LOST, 8'h00, 1'b0, 1'b0, 1'b0);
            carrier_up = 1'b0;
          end
        end
        // overrun empties the silo
        if (overrun_seen) begin
          overrun_seen = 1'b0;
          silo_wr = 8'd0;
          silo_rd = 8'd0;
          if (open_q) push_result(KIND_OVERFLOW, 8'h00, 1'b0, 1'b0, 1'b0);
        end
        // finished break
        if (break_due && !it.break_now) begin
          break_due = 1'b0;
          if (deliver) push_result(KIND_BREAK, 8'h00, 1'b0, 1'b0, 1'b0);
        end
        // drain up to the batch limit
        while (silo_rd != silo_wr && drained < cap) begin
          if (deliver) push_result(KIND_BYTE, silo_mem[silo_rd], 1'b0, 1'b0, 1'b0);
          silo_rd++;
          drained++;
        end
        more = (drained >= cap) && (silo_rd != silo_wr);
        soft_req = more;
      end
      default: ;
    endcase
    push_result(KIND_DONE, 8'h00, more, soft_req, 1'b1);
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h", got.kind,
                                got.out_byte));
      return;
    end
    want = expected_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.more_pending !== want.more_pending)
      report_mismatch($sformatf("more_pending %b, want %b", got.more_pending,
                                want.more_pending));
    if (got.soft_request !== want.soft_request)
      report_mismatch($sformatf("soft_request %b, want %b", got.soft_request,
                                want.soft_request));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
  endtask

  // Driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_results(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.payload <= pending_items.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter of the receiver
  always @(posedge clk) begin
    if (stall_seen != stall_requests) begin
      stall_seen <= stall_requests;
      stall_left <= 400;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: check each accepted result, then pick the next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.payload);
      out_ch.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic queue_item(action_t act, logic [7:0] b, bit brk, bit car, bit dovr,
                            bit full);
    in_item_t it;
    it.action = act;
    it.rx_byte = b;
    it.break_now = brk;
    it.carrier_now = car;
    it.data_overrun = dovr;
    it.downstream_full = full;
    pending_items.push_back(it);
    queued_total++;
  endtask

  task automatic queue_pass(bit full);
    queue_item(ACT_PASS, 8'($urandom), gen_brk, gen_car, 1'($urandom), full);
  endtask

  task automatic queue_bytes(int n, int null_pct);
    for (int i = 0; i < n; i++)
      queue_item(ACT_BYTE, ($urandom_range(0, 99) < null_pct) ? 8'h00 : 8'($urandom),
                 gen_brk, gen_car, 1'($urandom), 1'($urandom));
  endtask

  // Random traffic: mostly well-formed line sequences, some noise
  task automatic queue_line_traffic(int target);
    int start;
    int pick;
    start = queued_total;
    while (queued_total - start < target) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: begin
          // bytes then one or two passes
          queue_bytes(($urandom_range(0, 5) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 8), 12);
          queue_pass($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 2) == 0) queue_pass($urandom_range(0, 3) == 0);
        end
        4, 5: begin
          // break start, bytes with nulls, maybe a pass, break end, pass
          gen_brk = 1'b1;
          queue_item(ACT_STATUS, 8'($urandom), 1'b1, gen_car, 1'($urandom), 1'($urandom));
          queue_bytes($urandom_range(1, 4), 50);
          if ($urandom_range(0, 1) == 0) queue_pass(1'b0);
          gen_brk = 1'b0;
          queue_item(ACT_STATUS, 8'($urandom), 1'b0, gen_car, 1'($urandom), 1'($urandom));
          queue_pass($urandom_range(0, 3) == 0);
        end
        6: begin
          // carrier change then pass
          gen_car = 1'($urandom);
          queue_item(ACT_STATUS, 8'($urandom), gen_brk, gen_car, 1'($urandom),
                     1'($urandom));
          queue_pass($urandom_range(0, 3) == 0);
        end
        7: begin
          // receive error, a few bytes, pass
          queue_item(ACT_ERROR, 8'($urandom), gen_brk, gen_car, 1'($urandom),
                     1'($urandom));
          queue_bytes($urandom_range(0, 3), 12);
          queue_pass($urandom_range(0, 3) == 0);
        end
        default: begin
          // noise
          queue_item(action_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                     1'($urandom), 1'($urandom), 1'($urandom));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Write all four registers; the block is idle here
  task automatic write_settings(bit open, bit dial, logic [7:0] thr, logic [7:0] batch);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LINE_OPEN;
    cfg_wdata <= {7'd0, open};
    open_q = open;
    @(posedge clk);
    cfg_index <= CFG_DIALOUT_MODE;
    cfg_wdata <= {7'd0, dial};
    dialout_q = dial;
    @(posedge clk);
    cfg_index <= CFG_SOFT_THRESHOLD;
    cfg_wdata <= thr;
    soft_limit = thr;
    @(posedge clk);
    cfg_index <= CFG_BATCH_LIMIT;
    cfg_wdata <= batch;
    batch_reg = batch[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LINE_OPEN;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    silo_wr = 8'd0;
    silo_rd = 8'd0;
    overrun_seen = 1'b0;
    break_due = 1'b0;
    carrier_evt = 1'b0;
    soft_count = 0;
    line_in_break = 1'b0;
    carrier_up = 1'b0;
    open_q = 1'b0;
    dialout_q = 1'b0;
    soft_limit = SOFT_THRESHOLD_RST;
    batch_reg = BATCH_LIMIT_RST;
    gen_brk = 1'b0;
    gen_car = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 85;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: carrier, extreme bytes, soft request, batch limit, break, overrun, hangup
    write_settings(1'b1, 1'b0, 8'd2, 8'd3);
    queue_item(ACT_STATUS, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_PASS,   8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_BYTE,   8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_BYTE,   8'hFF, 1'b1, 1'b0, 1'b1, 1'b1);
    queue_item(ACT_BYTE,   8'hA5, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_BYTE,   8'h5A, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_PASS,   8'hFF, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_item(ACT_PASS,   8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_item(ACT_STATUS, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_BYTE,   8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_BYTE,   8'h7E, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_STATUS, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_PASS,   8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_PASS,   8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_ERROR,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_ERROR,  8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(ACT_BYTE,   8'h11, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_PASS,   8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_PASS,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(ACT_STATUS, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_STATUS, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(ACT_PASS,   8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
    gen_car = 1'b1;

    // Long burst with the widest threshold and batch
    wait_drained();
    write_settings(1'b1, 1'b1, 8'd255, 8'd60);
    queue_bytes(30, 5);
    queue_pass(1'b0);
    queue_pass(1'b0);
    queue_line_traffic(10);

    // Closed line, zero threshold and zero batch; sender mostly idle
    wait_drained();
    send_idle_pct = 85;
    recv_idle_pct = 25;
    write_settings(1'b0, 1'b0, 8'd0, 8'hC0);
    queue_line_traffic(12);

    // No idling, batch above range, long receiver hold-off
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(1'b1, 1'b0, 8'd7, 8'h3F);
    queue_bytes(24, 5);
    queue_pass(1'b0);
    stall_requests++;
    queue_line_traffic(8);

    // Threshold of one and smallest batch
    wait_drained();
    write_settings(1'b1, 1'b0, 8'd1, 8'd1);
    queue_line_traffic(8);

    wait_drained();
    repeat (40) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== serial_rx_silo_break_carrier.f =====
rtl/srsbc_pkg.sv
rtl/srsbc_if.sv
rtl/srsbc_ring.sv
rtl/serial_rx_silo_break_carrier.sv
dv/testbench.sv
